[rtl/sprq_pkg.sv]
// Shared types and constants for the stable priority ready queue.
package sprq_pkg;

    localparam int FUNC_W   = 2;
    localparam int HANDLE_W = 16;
    localparam int PRIO_W   = 8;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PRIO_PUSH = 2'd0,
        FUNC_TAIL_PUSH = 2'd1,
        FUNC_POP       = 2'd2,
        FUNC_PEEK      = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic push;
        logic pop;
        logic tail;
    } t_cell_ctl;

endpackage

[rtl/sprq_if.sv]
// Request and response channel interfaces of the ready queue.
interface sprq_req_if;
    logic                           valid;
    logic                           ready;
    logic [sprq_pkg::FUNC_W-1:0]    func;
    logic [sprq_pkg::HANDLE_W-1:0]  item_handle;
    logic [sprq_pkg::PRIO_W-1:0]    item_priority;

    modport source (output valid, func, item_handle, item_priority, input ready);
    modport sink   (input valid, func, item_handle, item_priority, output ready);
endinterface

interface sprq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           entry_valid;
    logic [sprq_pkg::HANDLE_W-1:0]  entry_handle;
    logic [sprq_pkg::PRIO_W-1:0]    entry_priority;
    logic [sprq_pkg::FILL_W-1:0]    fill_count;
    logic [sprq_pkg::STATUS_W-1:0]  status;

    modport source (output valid, entry_valid, entry_handle, entry_priority, fill_count,
                    status, input ready);
    modport sink   (input valid, entry_valid, entry_handle, entry_priority, fill_count,
                    status, output ready);
endinterface

[rtl/stable_priority_ready_queue_core.sv]
// Top level: stable priority ready queue built from a row of shift cells.
// Response: the beat is registered when the request beat is taken and appears next cycle.
// Throughput: one request per cycle unless an untaken response stalls; every cell decides
// and shifts in that cycle; a one-bit ripple along the cell row finds the insertion point.
// Reset: synchronous, active low; clears the slot valid bits, the fill count
// and the response valid flag. Slot contents and response fields are not reset.
module stable_priority_ready_queue_core #(
    parameter int CAPACITY      = 16,
    parameter int HANDLE_BITS   = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sprq_req_if.sink    i_req,
    sprq_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic                      r_entry_valid;
    logic [sprq_pkg::HANDLE_W-1:0] r_entry_handle;
    logic [sprq_pkg::PRIO_W-1:0]   r_entry_prio;
    logic [sprq_pkg::FILL_W-1:0]   r_fill;
    sprq_pkg::t_status         r_status;

    logic                      w_accept;
    sprq_pkg::t_func           w_func;
    logic                      w_full;
    logic                      w_empty;
    sprq_pkg::t_cell_ctl       w_ctl;
    logic [HANDLE_BITS-1:0]    w_new_handle;
    logic [PRIORITY_BITS-1:0]  w_new_prio;

    logic                      w_valid  [CAPACITY];
    logic [HANDLE_BITS-1:0]    w_handle [CAPACITY];
    logic [PRIORITY_BITS-1:0]  w_prio   [CAPACITY];
    logic                      w_flag   [CAPACITY+1];

    logic                      w_rep_valid;
    logic [HANDLE_BITS-1:0]    w_rep_handle;
    logic [PRIORITY_BITS-1:0]  w_rep_prio;
    sprq_pkg::t_status         w_rep_status;
    logic [sprq_pkg::HANDLE_W-1:0] w_out_handle;
    logic [sprq_pkg::PRIO_W-1:0]   w_out_prio;
    logic [sprq_pkg::FILL_W-1:0]   w_out_fill;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_func      = sprq_pkg::t_func'(i_req.func);
    assign w_full      = (r_count == CAP_CNT);
    assign w_empty     = (r_count == '0);

    // Width adaptation between port fields and stored entries
    for (genvar b = 0; b < HANDLE_BITS; b++) begin : g_new_h
        if (b < sprq_pkg::HANDLE_W) begin : g_bit
            assign w_new_handle[b] = i_req.item_handle[b];
        end else begin : g_zero
            assign w_new_handle[b] = 1'b0;
        end
    end
    for (genvar b = 0; b < PRIORITY_BITS; b++) begin : g_new_p
        if (b < sprq_pkg::PRIO_W) begin : g_bit
            assign w_new_prio[b] = i_req.item_priority[b];
        end else begin : g_zero
            assign w_new_prio[b] = 1'b0;
        end
    end
    for (genvar b = 0; b < sprq_pkg::HANDLE_W; b++) begin : g_out_h
        if (b < HANDLE_BITS) begin : g_bit
            assign w_out_handle[b] = w_rep_handle[b];
        end else begin : g_zero
            assign w_out_handle[b] = 1'b0;
        end
    end
    for (genvar b = 0; b < sprq_pkg::PRIO_W; b++) begin : g_out_p
        if (b < PRIORITY_BITS) begin : g_bit
            assign w_out_prio[b] = w_rep_prio[b];
        end else begin : g_zero
            assign w_out_prio[b] = 1'b0;
        end
    end
    for (genvar b = 0; b < sprq_pkg::FILL_W; b++) begin : g_out_f
        if (b < CNT_W) begin : g_bit
            assign w_out_fill[b] = n_count[b];
        end else begin : g_zero
            assign w_out_fill[b] = 1'b0;
        end
    end

    always_comb begin
        w_ctl = '0;
        unique case (w_func)
            sprq_pkg::FUNC_PRIO_PUSH: w_ctl.push = w_accept && !w_full;
            sprq_pkg::FUNC_TAIL_PUSH: begin
                w_ctl.push = w_accept && !w_full;
                w_ctl.tail = 1'b1;
            end
            sprq_pkg::FUNC_POP:       w_ctl.pop  = w_accept && !w_empty;
            sprq_pkg::FUNC_PEEK:      w_ctl      = '0;
            default:                  w_ctl      = '0;
        endcase
    end

    assign w_flag[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                     w_lv;
        logic [HANDLE_BITS-1:0]   w_lh;
        logic [PRIORITY_BITS-1:0] w_lp;
        logic                     w_rv;
        logic [HANDLE_BITS-1:0]   w_rh;
        logic [PRIORITY_BITS-1:0] w_rp;

        if (i == 0) begin : g_head
            assign w_lv = 1'b0;
            assign w_lh = '0;
            assign w_lp = '0;
        end else begin : g_mid
            assign w_lv = w_valid[i-1];
            assign w_lh = w_handle[i-1];
            assign w_lp = w_prio[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign w_rv = 1'b0;
            assign w_rh = '0;
            assign w_rp = '0;
        end else begin : g_body
            assign w_rv = w_valid[i+1];
            assign w_rh = w_handle[i+1];
            assign w_rp = w_prio[i+1];
        end

        sprq_cell #(
            .HANDLE_BITS   (HANDLE_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_new_handle   (w_new_handle),
            .i_new_prio     (w_new_prio),
            .i_left_valid   (w_lv),
            .i_left_handle  (w_lh),
            .i_left_prio    (w_lp),
            .i_right_valid  (w_rv),
            .i_right_handle (w_rh),
            .i_right_prio   (w_rp),
            .i_flag         (w_flag[i]),
            .o_flag         (w_flag[i+1]),
            .o_valid        (w_valid[i]),
            .o_handle       (w_handle[i]),
            .o_prio         (w_prio[i])
        );
    end

    // Result of the current request, from the row as it stands before the edge
    always_comb begin
        n_count      = r_count;
        w_rep_valid  = 1'b0;
        w_rep_handle = '0;
        w_rep_prio   = '0;
        w_rep_status = sprq_pkg::STATUS_OK;
        unique case (w_func)
            sprq_pkg::FUNC_PRIO_PUSH, sprq_pkg::FUNC_TAIL_PUSH: begin
                w_rep_valid = 1'b1;
                if (w_full) begin
                    w_rep_status = sprq_pkg::STATUS_FULL;
                    w_rep_handle = w_handle[0];
                    w_rep_prio   = w_prio[0];
                end else begin
                    n_count = r_count + CNT_W'(1);
                    // new entry lands in the head slot when cell 0 is the insertion point
                    if (w_flag[1]) begin
                        w_rep_handle = w_new_handle;
                        w_rep_prio   = w_new_prio;
                    end else begin
                        w_rep_handle = w_handle[0];
                        w_rep_prio   = w_prio[0];
                    end
                end
            end
            sprq_pkg::FUNC_POP, sprq_pkg::FUNC_PEEK: begin
                if (w_empty) begin
                    w_rep_status = sprq_pkg::STATUS_EMPTY;
                end else begin
                    w_rep_valid  = 1'b1;
                    w_rep_handle = w_handle[0];
                    w_rep_prio   = w_prio[0];
                    if (w_func == sprq_pkg::FUNC_POP) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry_valid  <= w_rep_valid;
            r_entry_handle <= w_out_handle;
            r_entry_prio   <= w_out_prio;
            r_fill         <= w_out_fill;
            r_status       <= w_rep_status;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.entry_valid    = r_entry_valid;
    assign o_rsp.entry_handle   = r_entry_handle;
    assign o_rsp.entry_priority = r_entry_prio;
    assign o_rsp.fill_count     = r_fill;
    assign o_rsp.status         = r_status;

endmodule

[rtl/sprq_cell.sv]
// One slot of the sorted shift row: holds an entry, shifts up on push, down on pop.
module sprq_cell #(
    parameter int HANDLE_BITS   = 16,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sprq_pkg::t_cell_ctl      i_ctl,
    input  logic [HANDLE_BITS-1:0]   i_new_handle,
    input  logic [PRIORITY_BITS-1:0] i_new_prio,
    input  logic                     i_left_valid,
    input  logic [HANDLE_BITS-1:0]   i_left_handle,
    input  logic [PRIORITY_BITS-1:0] i_left_prio,
    input  logic                     i_right_valid,
    input  logic [HANDLE_BITS-1:0]   i_right_handle,
    input  logic [PRIORITY_BITS-1:0] i_right_prio,
    input  logic                     i_flag,
    output logic                     o_flag,
    output logic                     o_valid,
    output logic [HANDLE_BITS-1:0]   o_handle,
    output logic [PRIORITY_BITS-1:0] o_prio
);

    logic                     r_valid;
    logic [HANDLE_BITS-1:0]   r_handle;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic                     n_valid;
    logic [HANDLE_BITS-1:0]   n_handle;
    logic [PRIORITY_BITS-1:0] n_prio;
    logic                     w_here;

    // Insertion point: first free slot, or for a priority push first strictly lower priority
    assign w_here = !r_valid || (!i_ctl.tail && (r_prio < i_new_prio));
    assign o_flag = i_flag || w_here;

    always_comb begin
        n_valid  = r_valid;
        n_handle = r_handle;
        n_prio   = r_prio;
        priority if (i_ctl.push) begin
            if (i_flag) begin
                n_valid  = i_left_valid;
                n_handle = i_left_handle;
                n_prio   = i_left_prio;
            end else if (w_here) begin
                n_valid  = 1'b1;
                n_handle = i_new_handle;
                n_prio   = i_new_prio;
            end
        end else if (i_ctl.pop) begin
            n_valid  = i_right_valid;
            n_handle = i_right_handle;
            n_prio   = i_right_prio;
        end else begin
            n_valid  = r_valid;
            n_handle = r_handle;
            n_prio   = r_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle <= n_handle;
        r_prio   <= n_prio;
    end

    assign o_valid  = r_valid;
    assign o_handle = r_handle;
    assign o_prio   = r_prio;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the stable priority ready queue core.
`timescale 1ns / 1ps

module testbench;

    localparam int QUEUE_DEPTH    = 16;
    localparam int RESET_CYCLES   = 6;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                          entry_valid;
        logic [sprq_pkg::HANDLE_W-1:0] entry_handle;
        logic [sprq_pkg::PRIO_W-1:0]   entry_priority;
        logic [sprq_pkg::FILL_W-1:0]   fill_count;
        sprq_pkg::t_status             status;
    } t_queue_report;

    typedef struct packed {
        sprq_pkg::t_func               op;
        logic [sprq_pkg::HANDLE_W-1:0] handle;
        logic [sprq_pkg::PRIO_W-1:0]   prio;
        logic                          pinned;
        t_queue_report                 report;
    } t_plan_row;

    localparam t_queue_report NO_REPORT    =
        '{1'b0, 16'h0000, 8'h00, 5'd0, sprq_pkg::STATUS_OK};
    localparam t_queue_report EMPTY_REPORT =
        '{1'b0, 16'h0000, 8'h00, 5'd0, sprq_pkg::STATUS_EMPTY};
    localparam t_queue_report FULL_REPORT  =
        '{1'b1, 16'hFFFF, 8'hFF, 5'd16, sprq_pkg::STATUS_FULL};

    // Rows with pinned set carry a hand-written report; the rest go to the predictor.
    localparam t_plan_row DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{sprq_pkg::FUNC_POP,       16'h0000, 8'h00, 1'b1, EMPTY_REPORT},
        '{sprq_pkg::FUNC_PEEK,      16'hFFFF, 8'hFF, 1'b1, EMPTY_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'hFFFF, 8'hFF, 1'b1,
          '{1'b1, 16'hFFFF, 8'hFF, 5'd1, sprq_pkg::STATUS_OK}},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'h0000, 8'h00, 1'b1,
          '{1'b1, 16'hFFFF, 8'hFF, 5'd2, sprq_pkg::STATUS_OK}},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'h1234, 8'hFF, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_TAIL_PUSH, 16'hAAAA, 8'hFF, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'h5555, 8'h80, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'h0001, 8'h00, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_TAIL_PUSH, 16'h8000, 8'hFE, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'h7FFF, 8'h7F, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'h00FF, 8'h01, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'hFF00, 8'hFE, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_TAIL_PUSH, 16'h0F0F, 8'h00, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'hF0F0, 8'h80, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'h3333, 8'h40, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'hCCCC, 8'hC0, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_TAIL_PUSH, 16'h6666, 8'h55, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'h9999, 8'hAA, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PRIO_PUSH, 16'h4242, 8'hFF, 1'b1, FULL_REPORT},
        '{sprq_pkg::FUNC_TAIL_PUSH, 16'h2424, 8'h00, 1'b1, FULL_REPORT},
        '{sprq_pkg::FUNC_PEEK,      16'h0000, 8'h00, 1'b1,
          '{1'b1, 16'hFFFF, 8'hFF, 5'd16, sprq_pkg::STATUS_OK}},
        '{sprq_pkg::FUNC_POP,       16'h0000, 8'h00, 1'b1,
          '{1'b1, 16'hFFFF, 8'hFF, 5'd15, sprq_pkg::STATUS_OK}},
        '{sprq_pkg::FUNC_POP,       16'h0000, 8'h00, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_PEEK,      16'h0000, 8'h00, 1'b0, NO_REPORT},
        '{sprq_pkg::FUNC_POP,       16'h0000, 8'h00, 1'b0, NO_REPORT}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sprq_req_if req_bus ();
    sprq_rsp_if rsp_bus ();

    stable_priority_ready_queue_core #(
        .CAPACITY      (QUEUE_DEPTH),
        .HANDLE_BITS   (sprq_pkg::HANDLE_W),
        .PRIORITY_BITS (sprq_pkg::PRIO_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the queue, head at index 0
    logic [sprq_pkg::HANDLE_W-1:0] slot_handles    [QUEUE_DEPTH];
    logic [sprq_pkg::PRIO_W-1:0]   slot_priorities [QUEUE_DEPTH];
    int                            queued_count;

    t_queue_report reports_due [$];
    int            fail_count;
    int            idle_cycles;
    bit            quiet_spell;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_queue_report serve_request(
            input sprq_pkg::t_func op,
            input logic [sprq_pkg::HANDLE_W-1:0] handle,
            input logic [sprq_pkg::PRIO_W-1:0] prio);
        t_queue_report rep;
        int            spot;
        rep = NO_REPORT;
        if (op == sprq_pkg::FUNC_PRIO_PUSH || op == sprq_pkg::FUNC_TAIL_PUSH) begin
            if (queued_count == QUEUE_DEPTH) begin
                rep.status = sprq_pkg::STATUS_FULL;
            end else begin
                spot = queued_count;
                // first slot holding a strictly lower priority; ties stay behind
                if (op == sprq_pkg::FUNC_PRIO_PUSH) begin
                    for (int i = queued_count - 1; i >= 0; i--)
                        if (slot_priorities[i] < prio)
                            spot = i;
                end
                for (int i = queued_count; i > spot; i--) begin
                    slot_handles[i]    = slot_handles[i-1];
                    slot_priorities[i] = slot_priorities[i-1];
                end
                slot_handles[spot]    = handle;
                slot_priorities[spot] = prio;
                queued_count++;
            end
            rep.entry_valid    = 1'b1;
            rep.entry_handle   = slot_handles[0];
            rep.entry_priority = slot_priorities[0];
        end else if (queued_count == 0) begin
            rep.status = sprq_pkg::STATUS_EMPTY;
        end else begin
            rep.entry_valid    = 1'b1;
            rep.entry_handle   = slot_handles[0];
            rep.entry_priority = slot_priorities[0];
            if (op == sprq_pkg::FUNC_POP) begin
                for (int i = 1; i < queued_count; i++) begin
                    slot_handles[i-1]    = slot_handles[i];
                    slot_priorities[i-1] = slot_priorities[i];
                end
                queued_count--;
            end
        end
        rep.fill_count = sprq_pkg::FILL_W'(queued_count);
        return rep;
    endfunction

    // Drives one request beat and waits for it to be taken
    task automatic send_request(input sprq_pkg::t_func op,
                                input logic [sprq_pkg::HANDLE_W-1:0] handle,
                                input logic [sprq_pkg::PRIO_W-1:0] prio,
                                input logic pinned,
                                input t_queue_report fixed);
        int            gap;
        t_queue_report rep;
        gap = quiet_spell ? 0 : pick_gap();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.func          <= op;
        req_bus.item_handle   <= handle;
        req_bus.item_priority <= prio;
        do @(posedge i_clk); while (!req_bus.ready);
        rep = serve_request(op, handle, prio);
        reports_due.push_back(pinned ? fixed : rep);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_rsp
        t_queue_report want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (reports_due.size() == 0) begin
                $error("response beat with no report outstanding");
                fail_count++;
            end else begin
                want = reports_due.pop_front();
                compare_field("entry_valid", 32'(want.entry_valid),
                              32'(rsp_bus.entry_valid));
                compare_field("entry_handle", 32'(want.entry_handle),
                              32'(rsp_bus.entry_handle));
                compare_field("entry_priority", 32'(want.entry_priority),
                              32'(rsp_bus.entry_priority));
                compare_field("fill_count", 32'(want.fill_count),
                              32'(rsp_bus.fill_count));
                compare_field("status", 32'(want.status), 32'(rsp_bus.status));
            end
        end
    end

    // Sink side back-pressure
    initial begin
        int stall_left;
        rsp_bus.ready = 1'b0;
        stall_left    = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_bus.ready <= 1'b1;
                if (!quiet_spell)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: too long without a beat on either side
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int                          left;
        int                          spell_len;
        int                          push_weight;
        int                          prio_style;
        sprq_pkg::t_func             op;
        logic [sprq_pkg::PRIO_W-1:0] prio;

        req_bus.valid         = 1'b0;
        req_bus.func          = sprq_pkg::FUNC_PRIO_PUSH;
        req_bus.item_handle   = '0;
        req_bus.item_priority = '0;
        fail_count   = 0;
        queued_count = 0;
        quiet_spell  = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_request(DIRECTED_PLAN[r].op, DIRECTED_PLAN[r].handle, DIRECTED_PLAN[r].prio,
                         DIRECTED_PLAN[r].pinned, DIRECTED_PLAN[r].report);

        // Spells of push-heavy, balanced and pop-heavy traffic so the queue
        // keeps running into both full and empty
        left = RANDOM_ITEMS;
        while (left > 0) begin
            spell_len   = $urandom_range(30, 90);
            prio_style  = $urandom_range(0, 2);
            quiet_spell = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       push_weight = 20;
                1:       push_weight = 50;
                default: push_weight = 80;
            endcase
            for (int k = 0; k < spell_len && left > 0; k++) begin
                if ($urandom_range(0, 99) < push_weight)
                    op = ($urandom_range(0, 3) == 0) ? sprq_pkg::FUNC_TAIL_PUSH
                                                     : sprq_pkg::FUNC_PRIO_PUSH;
                else
                    op = ($urandom_range(0, 3) == 0) ? sprq_pkg::FUNC_PEEK
                                                     : sprq_pkg::FUNC_POP;
                case (prio_style)
                    0: prio = sprq_pkg::PRIO_W'($urandom_range(0, 255));
                    1: prio = sprq_pkg::PRIO_W'($urandom_range(0, 3));     // heavy ties
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       prio = 8'h00;
                            1:       prio = 8'h01;
                            2:       prio = 8'hFE;
                            default: prio = 8'hFF;
                        endcase
                    end
                endcase
                send_request(op, sprq_pkg::HANDLE_W'($urandom_range(0, 65535)), prio,
                             1'b0, NO_REPORT);
                left--;
            end
        end
        req_bus.valid <= 1'b0;

        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
